FILE: design/cmg_pkg.sv
// Shared types and constants of the cylinder mesh generator.
package cmg_pkg;

	// largest usable segment count in either direction
	localparam int MaxSegments = 255;

	// odd Taylor terms of sin(pi/2 * x), Q30
	localparam logic [30:0] K1 = 31'd1686629713;
	localparam logic [30:0] K3 = 31'd693598668;
	localparam logic [30:0] K5 = 31'd85569306;
	localparam logic [30:0] K7 = 31'd5026995;
	localparam logic [30:0] K9 = 31'd172272;

	typedef enum logic [2:0] {
		RegSegAround,
		RegSegHigh,
		RegRadius,
		RegHeight,
		RegCenterX,
		RegCenterY,
		RegCenterZ,
		RegColor
	} cfg_reg_t;

	typedef enum logic {
		KindVertex,
		KindIndex
	} kind_t;

	typedef struct packed {
		kind_t       func;
		logic [7:0]  row;
		logic [8:0]  col;
	} req_t;

	typedef struct packed {
		kind_t              kind;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic [16:0]        tex_u;
		logic [16:0]        tex_v;
		logic [31:0]        color_out;
		logic [15:0]        index_first;
		logic [15:0]        index_second;
	} res_t;

	// everything that travels down the pipeline beside the arithmetic chains
	typedef struct packed {
		logic               v;
		kind_t              kind;
		logic [15:0]        idx_first;
		logic [15:0]        idx_second;
		logic [1:0]         quad;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic [16:0]        tex_u;
		logic [16:0]        tex_v;
		logic signed [17:0] dx;
		logic signed [17:0] dy;
		logic signed [17:0] dz;
		logic               lz;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
	} carry_t;

endpackage

FILE: design/cmg_req_if.sv
// Request channel: valid/ready handshake carrying one grid request per beat.
interface cmg_req_if import cmg_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/cmg_res_if.sv
// Result channel: valid/ready handshake carrying one vertex or index pair per beat.
interface cmg_res_if import cmg_pkg::*; ();
	logic valid;
	logic ready;
	res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/cylinder_mesh_generator.sv
// Throughput: one request per cycle while the skid register is free; every divider,
// root and polynomial cell is one stage.
// Requests outside the grid are dropped at the input and give no result beat.
// A result register plus one skid register part the output from the pipeline.
// Reset: configuration registers return to their defaults, all pipeline and output valid flags clear.
module cylinder_mesh_generator import cmg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	cmg_req_if.sink     req,
	cmg_res_if.source   res
);
	localparam int DivN      = 25;
	localparam int StDivOut  = 1 + DivN;
	localparam int StPre     = StDivOut + 1;
	localparam int StSine    = StPre + 6;
	localparam int StProd    = StSine + 1;
	localparam int StPos     = StProd + 1;
	localparam int StDiff    = StPos + 1;
	localparam int StSq      = StDiff + 1;
	localparam int StSum     = StSq + 1;
	localparam int SqrtN     = 31;
	localparam int StRoot    = StSum + SqrtN;
	localparam int StNormIn  = StRoot + 1;
	localparam int NormN     = 16;
	localparam int StNormOut = StNormIn + NormN;
	localparam int Last      = StNormOut + 1;

	// configuration
	logic [7:0]         seg_around_q;
	logic [7:0]         seg_high_q;
	logic [14:0]        radius_q;
	logic [14:0]        height_q;
	logic signed [15:0] center_x_q;
	logic signed [15:0] center_y_q;
	logic signed [15:0] center_z_q;
	logic [31:0]        color_q;

	logic [7:0]  s_eff;
	logic [7:0]  h_eff;
	logic        en;
	logic        grid_ok;
	logic        stitch;
	logic [9:0]  s_plus1;
	logic [8:0]  w9;
	logic [17:0] prod0, prod1, prod2;
	carry_t      c1;

	carry_t      carry_q [1:Last];
	carry_t      carry_d [1:Last];
	logic [32:0] num_s1 [4];
	logic [32:0] dv_rem [4][DivN+1];
	logic [7:0]  dv_den [4][DivN+1];
	logic [DivN-1:0] dv_q [4][DivN+1];

	logic [23:0] phase;
	logic [30:0] xa_s27, xb_s27;
	logic [30:0] sin_a, sin_b;
	logic [46:0] prod_a_s34, prod_b_s34;
	logic [14:0] mag_a, mag_b;
	logic signed [15:0] px, pz;
	logic signed [35:0] sqx, sqy, sqz;
	logic [31:0] sq_s37 [3];
	logic [33:0] l_s38;
	logic [61:0] sq_rad [SqrtN+1];
	logic [61:0] sq_rt [SqrtN+1];
	logic [30:0] root;
	logic [30:0] r_s70;
	logic [44:0] num_s70 [3];
	logic [44:0] nd_rem [3][NormN+1];
	logic [30:0] nd_den [3][NormN+1];
	logic [15:0] nd_q [3][NormN+1];
	logic signed [15:0] nrm [3];

	res_t res_nxt;
	logic res_v_q, skid_v_q;
	res_t res_d_q, skid_d_q;

	function automatic logic [14:0] cap_mag(input logic [46:0] p);
		logic [16:0] m;
		m = p[46:30];
		return (m > 17'd32767) ? 15'h7FFF : m[14:0];
	endfunction

	function automatic logic [16:0] abs18(input logic signed [17:0] d);
		logic signed [17:0] a;
		a = (d < 0) ? -d : d;
		return a[16:0];
	endfunction

	function automatic logic signed [15:0] norm_out(input logic [15:0] q,
			input logic signed [17:0] d, input logic lz);
		logic [14:0] mag;
		mag = (q > 16'd16384) ? 15'd16384 : q[14:0];
		if (lz) return '0;
		return (d < 0) ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	endfunction

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_around_q <= 8'd16;
			seg_high_q   <= 8'd1;
			radius_q     <= 15'd256;
			height_q     <= 15'd256;
			center_x_q   <= '0;
			center_y_q   <= '0;
			center_z_q   <= '0;
			color_q      <= 32'hFFFF_FFFF;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				RegSegAround: seg_around_q <= cfg_data[7:0];
				RegSegHigh:   seg_high_q   <= cfg_data[7:0];
				RegRadius:    radius_q     <= cfg_data[14:0];
				RegHeight:    height_q     <= cfg_data[14:0];
				RegCenterX:   center_x_q   <= cfg_data[15:0];
				RegCenterY:   center_y_q   <= cfg_data[15:0];
				RegCenterZ:   center_z_q   <= cfg_data[15:0];
				RegColor:     color_q      <= cfg_data;
			endcase
		end
	end

	assign s_eff = (seg_around_q > 8'(MaxSegments)) ? 8'(MaxSegments) : seg_around_q;
	assign h_eff = (seg_high_q > 8'(MaxSegments)) ? 8'(MaxSegments) : seg_high_q;

	// the pipeline moves whenever the skid register is free
	assign en        = !skid_v_q;
	assign req.ready = en;

	// grid check and strip indices of the incoming beat
	always_comb begin
		s_plus1 = {2'b0, s_eff} + 10'd1;
		w9      = {1'b0, s_eff} + 9'd1;
		stitch  = {1'b0, req.data.col} == s_plus1;
		if (s_eff == 8'd0 || h_eff == 8'd0) begin
			grid_ok = 1'b0;
		end else if (req.data.func == KindIndex) begin
			grid_ok = (req.data.row < h_eff) && ({1'b0, req.data.col} <= s_plus1)
				&& !(stitch && ({1'b0, req.data.row} + 9'd1 >= {1'b0, h_eff}));
		end else begin
			grid_ok = (req.data.row <= h_eff) && (req.data.col <= {1'b0, s_eff});
		end
		prod0 = 18'(req.data.row) * 18'(w9);
		prod1 = 18'({1'b0, req.data.row} + 9'd1) * 18'(w9);
		prod2 = 18'({1'b0, req.data.row} + 9'd2) * 18'(w9);
		c1 = '0;
		c1.v    = req.valid && grid_ok;
		c1.kind = req.data.func;
		if (stitch) begin
			c1.idx_first  = prod0[15:0] + 16'(s_eff);
			c1.idx_second = prod2[15:0];
		end else begin
			c1.idx_first  = prod1[15:0] + 16'(req.data.col);
			c1.idx_second = prod0[15:0] + 16'(req.data.col);
		end
	end

	// chain inputs: phase, texture u, texture v and height numerators
	always_ff @(posedge clk) begin
		if (en) begin
			num_s1[0] <= {req.data.col, 24'b0} + 33'(s_eff >> 1);
			num_s1[1] <= 33'({req.data.col, 16'b0}) + 33'(s_eff >> 1);
			num_s1[2] <= 33'({req.data.row, 16'b0}) + 33'(h_eff >> 1);
			num_s1[3] <= 33'(23'(height_q) * 23'(req.data.row)) + 33'(h_eff >> 1);
		end
	end

	// four divider chains, one quotient bit per cell
	for (genvar c = 0; c < 4; c++) begin : g_div
		assign dv_rem[c][0] = num_s1[c];
		assign dv_den[c][0] = (c < 2) ? s_eff : h_eff;
		assign dv_q[c][0]   = '0;
		for (genvar k = 0; k < DivN; k++) begin : g_cell
			cmg_div_cell #(.NUM_W(33), .DEN_W(8), .Q_W(DivN), .BIT(DivN - 1 - k)) u_cell (
				.clk   (clk),
				.en    (en),
				.rem   (dv_rem[c][k]),
				.den   (dv_den[c][k]),
				.quo   (dv_q[c][k]),
				.rem_q (dv_rem[c][k+1]),
				.den_q (dv_den[c][k+1]),
				.quo_q (dv_q[c][k+1])
			);
		end
	end

	assign phase = dv_q[0][DivN][23:0];

	// split phase into quadrant and the two complementary sine arguments
	always_ff @(posedge clk) begin
		if (en) begin
			xa_s27 <= {1'b0, phase[21:0], 8'b0};
			xb_s27 <= {23'h40_0000 - {1'b0, phase[21:0]}, 8'b0};
		end
	end

	cmg_sine u_sine_a (.clk(clk), .en(en), .x(xa_s27), .sine_s6(sin_a));
	cmg_sine u_sine_b (.clk(clk), .en(en), .x(xb_s27), .sine_s6(sin_b));

	// scale by radius, place on the circle by quadrant
	always_comb begin
		mag_a = cap_mag(prod_a_s34);
		mag_b = cap_mag(prod_b_s34);
		unique case (carry_q[StProd].quad)
			2'd0: begin px =  $signed({1'b0, mag_a}); pz =  $signed({1'b0, mag_b}); end
			2'd1: begin px =  $signed({1'b0, mag_b}); pz = -$signed({1'b0, mag_a}); end
			2'd2: begin px = -$signed({1'b0, mag_a}); pz = -$signed({1'b0, mag_b}); end
			2'd3: begin px = -$signed({1'b0, mag_b}); pz =  $signed({1'b0, mag_a}); end
		endcase
		sqx = carry_q[StDiff].dx * carry_q[StDiff].dx;
		sqy = carry_q[StDiff].dy * carry_q[StDiff].dy;
		sqz = carry_q[StDiff].dz * carry_q[StDiff].dz;
	end

	// products, squares and the squared length
	always_ff @(posedge clk) begin
		if (en) begin
			prod_a_s34 <= 47'(sin_a) * 47'(radius_q) + 47'(1 << 29);
			prod_b_s34 <= 47'(sin_b) * 47'(radius_q) + 47'(1 << 29);
			sq_s37[0]  <= sqx[31:0];
			sq_s37[1]  <= sqy[31:0];
			sq_s37[2]  <= sqz[31:0];
			l_s38      <= 34'(sq_s37[0]) + 34'(sq_s37[1]) + 34'(sq_s37[2]);
		end
	end

	// root chain over the scaled squared length
	assign sq_rad[0] = {l_s38, 28'b0};
	assign sq_rt[0]  = '0;
	for (genvar j = 0; j < SqrtN; j++) begin : g_sqrt
		cmg_sqrt_cell #(.VW(62), .BIT(2 * (SqrtN - 1 - j))) u_cell (
			.clk   (clk),
			.en    (en),
			.rad   (sq_rad[j]),
			.rt    (sq_rt[j]),
			.rad_q (sq_rad[j+1]),
			.rt_q  (sq_rt[j+1])
		);
	end

	assign root = sq_rt[SqrtN][30:0];

	// normal numerators with half-divisor rounding
	always_ff @(posedge clk) begin
		if (en) begin
			r_s70      <= root;
			num_s70[0] <= {abs18(carry_q[StRoot].dx), 28'b0} + 45'(root >> 1);
			num_s70[1] <= {abs18(carry_q[StRoot].dy), 28'b0} + 45'(root >> 1);
			num_s70[2] <= {abs18(carry_q[StRoot].dz), 28'b0} + 45'(root >> 1);
		end
	end

	// three normal divider chains
	for (genvar i = 0; i < 3; i++) begin : g_norm
		assign nd_rem[i][0] = num_s70[i];
		assign nd_den[i][0] = r_s70;
		assign nd_q[i][0]   = '0;
		for (genvar k = 0; k < NormN; k++) begin : g_cell
			cmg_div_cell #(.NUM_W(45), .DEN_W(31), .Q_W(NormN), .BIT(NormN - 1 - k)) u_cell (
				.clk   (clk),
				.en    (en),
				.rem   (nd_rem[i][k]),
				.den   (nd_den[i][k]),
				.quo   (nd_q[i][k]),
				.rem_q (nd_rem[i][k+1]),
				.den_q (nd_den[i][k+1]),
				.quo_q (nd_q[i][k+1])
			);
		end
	end

	assign nrm[0] = norm_out(nd_q[0][NormN], carry_q[StNormOut].dx, carry_q[StNormOut].lz);
	assign nrm[1] = norm_out(nd_q[1][NormN], carry_q[StNormOut].dy, carry_q[StNormOut].lz);
	assign nrm[2] = norm_out(nd_q[2][NormN], carry_q[StNormOut].dz, carry_q[StNormOut].lz);

	// side pipeline: shift every stage, fill in fields as they become known
	always_comb begin
		carry_d[1] = c1;
		for (int k = 2; k <= Last; k++) carry_d[k] = carry_q[k-1];
		carry_d[StPre].quad  = phase[23:22];
		carry_d[StPre].tex_u = dv_q[1][DivN][16:0];
		carry_d[StPre].tex_v = dv_q[2][DivN][16:0];
		carry_d[StPre].pos_y = $signed({1'b0, height_q} - dv_q[3][DivN][15:0]);
		carry_d[StPos].pos_x = px;
		carry_d[StPos].pos_z = pz;
		carry_d[StDiff].dx   = 18'(carry_q[StPos].pos_x) - 18'(center_x_q);
		carry_d[StDiff].dy   = 18'(carry_q[StPos].pos_y) - 18'(center_y_q);
		carry_d[StDiff].dz   = 18'(carry_q[StPos].pos_z) - 18'(center_z_q);
		carry_d[StNormIn].lz = root == 31'd0;
		carry_d[Last].nx     = nrm[0];
		carry_d[Last].ny     = nrm[1];
		carry_d[Last].nz     = nrm[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= Last; k++) carry_q[k] <= '0;
		end else if (en) begin
			for (int k = 1; k <= Last; k++) carry_q[k] <= carry_d[k];
		end
	end

	// assemble the result beat, zeroing fields of the other kind
	always_comb begin
		res_nxt      = '0;
		res_nxt.kind = carry_q[Last].kind;
		if (carry_q[Last].kind == KindIndex) begin
			res_nxt.index_first  = carry_q[Last].idx_first;
			res_nxt.index_second = carry_q[Last].idx_second;
		end else begin
			res_nxt.pos_x     = carry_q[Last].pos_x;
			res_nxt.pos_y     = carry_q[Last].pos_y;
			res_nxt.pos_z     = carry_q[Last].pos_z;
			res_nxt.normal_x  = carry_q[Last].nx;
			res_nxt.normal_y  = carry_q[Last].ny;
			res_nxt.normal_z  = carry_q[Last].nz;
			res_nxt.tex_u     = carry_q[Last].tex_u;
			res_nxt.tex_v     = carry_q[Last].tex_v;
			res_nxt.color_out = color_q;
		end
	end

	// output register and skid: hold a stalled beat, park the next one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (en) begin
			if (carry_q[Last].v) begin
				if (!res_v_q || res.ready) res_v_q <= 1'b1;
				else skid_v_q <= 1'b1;
			end else if (res.ready) begin
				res_v_q <= 1'b0;
			end
		end else if (res.ready) begin
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (carry_q[Last].v) begin
				if (!res_v_q || res.ready) res_d_q <= res_nxt;
				else skid_d_q <= res_nxt;
			end
		end else if (res.ready) begin
			res_d_q <= skid_d_q;
		end
	end

	assign res.valid = res_v_q;
	assign res.data  = res_d_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> res_v_q)
		else $error("skid holds a beat while the output register is empty");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(carry_q[Last].v))
		else $error("last stage moved during a stall");

	a_vertex_no_index: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.data.kind == KindVertex)
		|-> (res.data.index_first == 16'd0 && res.data.index_second == 16'd0))
		else $error("vertex beat carries index fields");

	a_normal_range: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.data.kind == KindVertex)
		|-> (res.data.normal_x <= 16'sd16384 && res.data.normal_x >= -16'sd16384
			&& res.data.normal_z <= 16'sd16384 && res.data.normal_z >= -16'sd16384))
		else $error("normal component beyond unit length");

	a_index_no_vertex: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.data.kind == KindIndex)
		|-> (res.data.color_out == 32'd0 && res.data.tex_u == 17'd0))
		else $error("index beat carries vertex fields");
endmodule

FILE: design/cmg_div_cell.sv
// One restoring-division cell: settles a single quotient bit and passes on.
module cmg_div_cell #(
	parameter int NUM_W = 33,
	parameter int DEN_W = 8,
	parameter int Q_W   = 25,
	parameter int BIT   = 0
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] rem,
	input  logic [DEN_W-1:0] den,
	input  logic [Q_W-1:0]   quo,
	output logic [NUM_W-1:0] rem_q,
	output logic [DEN_W-1:0] den_q,
	output logic [Q_W-1:0]   quo_q
);
	localparam int CW = NUM_W + DEN_W;

	logic [CW-1:0]    shifted;
	logic [CW-1:0]    wide_rem;
	logic [CW-1:0]    diff;
	logic             fits;
	logic [Q_W-1:0]   quo_nxt;

	// trial subtract of the divisor at this bit weight
	always_comb begin
		shifted  = CW'(den) << BIT;
		wide_rem = CW'(rem);
		diff     = wide_rem - shifted;
		fits     = wide_rem >= shifted;
		quo_nxt  = quo;
		quo_nxt[BIT] = fits;
	end

	// hand remainder, divisor and quotient to the next cell
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= fits ? diff[NUM_W-1:0] : rem;
			den_q <= den;
			quo_q <= quo_nxt;
		end
	end
endmodule

FILE: design/cmg_sqrt_cell.sv
// One digit-by-digit square root cell: settles one root bit and passes on.
module cmg_sqrt_cell #(
	parameter int VW  = 62,
	parameter int BIT = 0
) (
	input  logic          clk,
	input  logic          en,
	input  logic [VW-1:0] rad,
	input  logic [VW-1:0] rt,
	output logic [VW-1:0] rad_q,
	output logic [VW-1:0] rt_q
);
	logic [VW-1:0] bval;
	logic [VW-1:0] trial;
	logic          take;

	// compare remainder with root plus the current power of four
	always_comb begin
		bval  = VW'(1) << BIT;
		trial = rt + bval;
		take  = rad >= trial;
	end

	// advance remainder and partial root
	always_ff @(posedge clk) begin
		if (en) begin
			rad_q <= take ? rad - trial : rad;
			rt_q  <= take ? (rt >> 1) + bval : rt >> 1;
		end
	end
endmodule

FILE: design/cmg_sine.sv
// Quarter-wave sine: Horner evaluation of the odd polynomial, one multiply per stage.
module cmg_sine import cmg_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [30:0] x,
	output logic [30:0] sine_s6
);
	logic [30:0] x_s1, x_s2, x_s3, x_s4, x_s5;
	logic [30:0] x2_s1, x2_s2, x2_s3, x2_s4;
	logic [30:0] t_s2, t_s3, t_s4, t_s5;
	logic [61:0] sq;
	logic [61:0] fin;

	function automatic logic [30:0] horner(input logic [30:0] k, input logic [30:0] a,
			input logic [30:0] b);
		logic [61:0] p;
		p = 62'(a) * 62'(b);
		return k - p[60:30];
	endfunction

	assign sq  = 62'(x) * 62'(x);
	assign fin = 62'(x_s5) * 62'(t_s5);

	// step through the polynomial, carrying x and x squared alongside
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= x;
			x2_s1   <= sq[60:30];
			x_s2    <= x_s1;
			x2_s2   <= x2_s1;
			t_s2    <= horner(K7, x2_s1, K9);
			x_s3    <= x_s2;
			x2_s3   <= x2_s2;
			t_s3    <= horner(K5, x2_s2, t_s2);
			x_s4    <= x_s3;
			x2_s4   <= x2_s3;
			t_s4    <= horner(K3, x2_s3, t_s3);
			x_s5    <= x_s4;
			t_s5    <= horner(K1, x2_s4, t_s4);
			sine_s6 <= fin[60:30];
		end
	end
endmodule
